// ===== hw/rtl/ceagm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ceagm_pkg;

	localparam int AGM_ROUNDS = 8;
	localparam int FRAC_BITS  = 60;
	localparam int OUT_FRAC   = 28;
	localparam int ROUND_W    = $clog2(AGM_ROUNDS + 1);

	localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS;
	localparam logic [63:0] PI_HALF     = PI_HALF_Q62 >> (62 - FRAC_BITS);
	localparam logic [63:0] SUM_CAP     = 64'h8000_0000_0000_0000;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ0, S_SQ0W,
		S_G0, S_G0W,
		S_KMUL, S_KMULW, S_KSQ, S_KSQW,
		S_EMUL, S_EMULW, S_ESQ, S_ESQW,
		S_DMUL, S_DMULW, S_ACC,
		S_TMUL, S_TMULW,
		S_DIVK, S_DIVKW, S_DIVE, S_DIVEW,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQRT_COMP,
		OP_WB_SQ,
		OP_SQRT_SQ,
		OP_WB_G,
		OP_MUL_AG,
		OP_SQRT_PROD,
		OP_WB_KR,
		OP_MUL_E,
		OP_WB_ER,
		OP_MUL_D,
		OP_ACC,
		OP_MUL_T,
		OP_DIV_K,
		OP_WB_K,
		OP_DIV_E,
		OP_WB_E,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic [ROUND_W-1:0] rnd;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ceagm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ceagm_param_if;
	logic        valid;
	logic        ready;
	logic [31:0] modulus_param;
	modport source (output valid, output modulus_param, input ready);
	modport sink (input valid, input modulus_param, output ready);
endinterface

interface ceagm_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_kind;
	logic [31:0] second_kind;
	modport source (output valid, output first_kind, output second_kind, input ready);
	modport sink (input valid, input first_kind, input second_kind, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ceagm_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ceagm_sqrt
	import ceagm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] rad,
	output logic              done,
	output logic [63:0]       root
);

	logic         busy_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [127:0] rad_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;

	logic [67:0] rem_sh;
	logic [67:0] trial;
	logic        ge;
	logic [67:0] rem_nx;

	// one result bit per step: bring down two radicand bits, try 4r+1
	always_comb begin
		rem_sh = {rem_q, rad_q[127:126]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[125:0], 2'b00};
			rem_q  <= rem_nx[65:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ceagm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ceagm_div
	import ceagm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] num,
	input  wire logic [63:0]  den,
	output logic              done,
	output logic [63:0]       quot
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] q_q;
	logic [63:0] d_q;

	logic        ovf;
	logic        carry;
	logic [63:0] rs;
	logic        sub;

	always_comb begin
		ovf   = (den == 64'd0) || (num[127:64] >= den);
		carry = rem_q[63];
		rs    = {rem_q[62:0], lo_q[63]};
		sub   = carry || (rs >= d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[127:64];
			lo_q  <= num[63:0];
			d_q   <= den;
			q_q   <= ovf ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= sub ? rs - d_q : rs;
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], sub};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ceagm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ceagm_dp
	import ceagm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire dp_cmd_t cmd,
	output dp_stat_t     stat,
	input  wire logic [31:0] modulus_param,
	output logic [31:0]  first_kind,
	output logic [31:0]  second_kind
);

	logic [63:0] mf_q, comp_q, sq_q, a_q, g_q, ea_q, eg_q, sum_q;
	logic [31:0] k_q, e_q, fk_q, sk_q;

	// shared multiplier: one 32x32 partial product per cycle
	logic         mbusy_q, mdone_q;
	logic [1:0]   mcnt_q;
	logic [63:0]  mx_q, my_q;
	logic [127:0] acc_q;
	logic         mstart;
	logic [63:0]  mx_in, my_in;
	logic [31:0]  px, py;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	logic         sstart, sdone;
	logic [127:0] srad;
	logic [63:0]  sroot;
	logic         dstart, ddone;
	logic [127:0] dnum;
	logic [63:0]  dquot;
	logic [31:0]  dsat;

	logic [63:0]  d_diff, pos, neg, t_val;
	logic [6:0]   tsh;
	logic [127:0] term;
	logic [63:0]  room;
	logic [64:0]  kmean, emean;

	always_comb begin
		d_diff = ea_q - eg_q;
		pos    = ONE + sq_q;
		neg    = {1'b0, mf_q[63:1]} + sum_q;
		t_val  = (pos > neg) ? pos - neg : 64'd0;
		kmean  = {1'b0, a_q} + {1'b0, g_q};
		emean  = {1'b0, ea_q} + {1'b0, eg_q};
		tsh    = 7'(FRAC_BITS + 2) - 7'(cmd.rnd);
		term   = acc_q >> tsh;
		room   = SUM_CAP - sum_q;
		dsat   = (|dquot[63:32]) ? 32'hFFFF_FFFF : dquot[31:0];
	end

	always_comb begin
		mstart = 1'b1;
		mx_in  = a_q;
		my_in  = g_q;
		case (cmd.op)
			OP_MUL_AG: begin
				mx_in = a_q;
				my_in = g_q;
			end
			OP_MUL_E: begin
				mx_in = ea_q;
				my_in = eg_q;
			end
			OP_MUL_D: begin
				mx_in = d_diff;
				my_in = d_diff;
			end
			OP_MUL_T: begin
				mx_in = t_val;
				my_in = PI_HALF;
			end
			default: mstart = 1'b0;
		endcase
	end

	always_comb begin
		px = mcnt_q[1] ? mx_q[63:32] : mx_q[31:0];
		py = mcnt_q[0] ? my_q[63:32] : my_q[31:0];
		pp = 64'(px) * 64'(py);
		case (mcnt_q)
			2'd0:    pp_sh = 128'(pp);
			2'd3:    pp_sh = 128'(pp) << 64;
			default: pp_sh = 128'(pp) << 32;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mstart) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mstart) begin
			mx_q  <= mx_in;
			my_q  <= my_in;
			acc_q <= '0;
		end else if (mbusy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	always_comb begin
		sstart = 1'b1;
		case (cmd.op)
			OP_SQRT_COMP: srad = 128'(comp_q) << FRAC_BITS;
			OP_SQRT_SQ:   srad = 128'(sq_q) << FRAC_BITS;
			OP_SQRT_PROD: srad = acc_q;
			default: begin
				srad   = acc_q;
				sstart = 1'b0;
			end
		endcase
	end

	always_comb begin
		dstart = 1'b1;
		case (cmd.op)
			OP_DIV_K: dnum = 128'(PI_HALF) << OUT_FRAC;
			OP_DIV_E: dnum = acc_q >> (FRAC_BITS - OUT_FRAC + 1);
			default: begin
				dnum   = acc_q;
				dstart = 1'b0;
			end
		endcase
	end

	ceagm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sstart),
		.rad    (srad),
		.done   (sdone),
		.root   (sroot)
	);

	ceagm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    (a_q),
		.done   (ddone),
		.quot   (dquot)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mf_q   <= 64'(modulus_param) << (FRAC_BITS - 32);
				comp_q <= ONE - (64'(modulus_param) << (FRAC_BITS - 32));
				sum_q  <= '0;
			end
			OP_WB_SQ: begin
				sq_q <= sroot;
				eg_q <= sroot;
				ea_q <= 64'((65'(comp_q) + 65'(ONE)) >> 1);
				a_q  <= 64'((65'(ONE) + 65'(sroot)) >> 1);
			end
			OP_WB_G: g_q <= sroot;
			OP_WB_KR: begin
				a_q <= kmean[64:1];
				g_q <= sroot;
			end
			OP_WB_ER: begin
				ea_q <= emean[64:1];
				eg_q <= sroot;
			end
			OP_ACC: begin
				// saturate the running sum at the cap
				if ((|term[127:64]) || (term[63:0] > room))
					sum_q <= SUM_CAP;
				else
					sum_q <= sum_q + term[63:0];
			end
			OP_WB_K: k_q <= dsat;
			OP_WB_E: e_q <= dsat;
			default: ;
		endcase
		// capture both halves of the result word when it is emitted; hold them until the next emit
		if (cmd.op == OP_EMIT) begin
			fk_q <= k_q;
			sk_q <= e_q;
		end
	end

	assign stat.mul_done  = mdone_q;
	assign stat.sqrt_done = sdone;
	assign stat.div_done  = ddone;
	assign first_kind     = fk_q;
	assign second_kind    = sk_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ceagm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ceagm_ctrl
	import ceagm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t        state_q, state_nx;
	logic [ROUND_W-1:0] rnd_q;
	logic               out_valid_q;
	logic               emit;
	logic               last_rnd;

	assign last_rnd = (rnd_q == ROUND_W'(AGM_ROUNDS));
	assign emit     = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nx = S_SQ0;
			S_SQ0:   state_nx = S_SQ0W;
			S_SQ0W:  if (stat.sqrt_done) state_nx = S_G0;
			S_G0:    state_nx = S_G0W;
			S_G0W:   if (stat.sqrt_done) state_nx = S_KMUL;
			S_KMUL:  state_nx = S_KMULW;
			S_KMULW: if (stat.mul_done) state_nx = S_KSQ;
			S_KSQ:   state_nx = S_KSQW;
			S_KSQW:  if (stat.sqrt_done) state_nx = last_rnd ? S_EMUL : S_KMUL;
			S_EMUL:  state_nx = S_EMULW;
			S_EMULW: if (stat.mul_done) state_nx = S_ESQ;
			S_ESQ:   state_nx = S_ESQW;
			S_ESQW:  if (stat.sqrt_done) state_nx = S_DMUL;
			S_DMUL:  state_nx = S_DMULW;
			S_DMULW: if (stat.mul_done) state_nx = S_ACC;
			S_ACC:   state_nx = last_rnd ? S_TMUL : S_EMUL;
			S_TMUL:  state_nx = S_TMULW;
			S_TMULW: if (stat.mul_done) state_nx = S_DIVK;
			S_DIVK:  state_nx = S_DIVKW;
			S_DIVKW: if (stat.div_done) state_nx = S_DIVE;
			S_DIVE:  state_nx = S_DIVEW;
			S_DIVEW: if (stat.div_done) state_nx = S_OUT;
			S_OUT:   if (emit) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.rnd  = rnd_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_SQ0:   cmd.op = OP_SQRT_COMP;
			S_SQ0W:  if (stat.sqrt_done) cmd.op = OP_WB_SQ;
			S_G0:    cmd.op = OP_SQRT_SQ;
			S_G0W:   if (stat.sqrt_done) cmd.op = OP_WB_G;
			S_KMUL:  cmd.op = OP_MUL_AG;
			S_KSQ:   cmd.op = OP_SQRT_PROD;
			S_KSQW:  if (stat.sqrt_done) cmd.op = OP_WB_KR;
			S_EMUL:  cmd.op = OP_MUL_E;
			S_ESQ:   cmd.op = OP_SQRT_PROD;
			S_ESQW:  if (stat.sqrt_done) cmd.op = OP_WB_ER;
			S_DMUL:  cmd.op = OP_MUL_D;
			S_ACC:   cmd.op = OP_ACC;
			S_TMUL:  cmd.op = OP_MUL_T;
			S_DIVK:  cmd.op = OP_DIV_K;
			S_DIVKW: if (stat.div_done) cmd.op = OP_WB_K;
			S_DIVE:  cmd.op = OP_DIV_E;
			S_DIVEW: if (stat.div_done) cmd.op = OP_WB_E;
			S_OUT:   if (emit) cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rnd_q       <= ROUND_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// advance the round count at the end of each round of either chain
			if ((state_q == S_KSQW && stat.sqrt_done) || state_q == S_ACC)
				rnd_q <= last_rnd ? ROUND_W'(1) : rnd_q + ROUND_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/complete_elliptic_integrals_agm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Word                               Format
// param     in   modulus_param                      unsigned Q0.32
// result    out  first_kind, second_kind            unsigned Q4.28 each
//
// One word in flight at a time; the work per word is dominated by the
// bit-serial square root unit (18 roots of 64 steps each), plus two 64-step
// divisions and 25 multiplies on the shared multiplier.
// A finished word waits in the result register while the next one is taken.
// arst_n clears the control and handshake flops; datapath registers are not reset.
module complete_elliptic_integrals_agm
	import ceagm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	ceagm_param_if.sink   param,
	ceagm_result_if.source result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ceagm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (param.valid),
		.in_ready  (param.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ceagm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.modulus_param (param.modulus_param),
		.first_kind    (result.first_kind),
		.second_kind   (result.second_kind)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/ceagm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ceagm_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] first_kind,
	input wire logic [31:0] second_kind
);

	// one word at a time: the input closes once a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a take");

	a_busy_long: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##3 !in_ready)
		else $error("input ready too soon after a take");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_kind) && $stable(second_kind))
		else $error("stalled result changed");

endmodule

bind complete_elliptic_integrals_agm ceagm_props u_ceagm_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (param.valid),
	.in_ready    (param.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.first_kind  (result.first_kind),
	.second_kind (result.second_kind)
);
`default_nettype wire
